// ===== hdl/abar_pkg.sv =====
// shared types and constants of the adc block average reporter
`timescale 1ns / 1ps
`default_nettype none

package abar_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned READING_W  = 12;
  localparam int unsigned CHAN_ID_W  = 4;
  localparam int unsigned TYPE_W     = 2;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned NUM_SLOTS  = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_A_CHANNEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_TYPE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A_PERIOD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_CHANNEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B_TYPE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_B_PERIOD  = 3'd5;

  // register reset values
  localparam logic [CHAN_ID_W-1:0] RST_A_CHANNEL = 4'd1;
  localparam logic [TYPE_W-1:0]    RST_A_TYPE    = 2'd0;
  localparam logic [PERIOD_W-1:0]  RST_A_PERIOD  = 16'd5;
  localparam logic [CHAN_ID_W-1:0] RST_B_CHANNEL = 4'd2;
  localparam logic [TYPE_W-1:0]    RST_B_TYPE    = 2'd1;
  localparam logic [PERIOD_W-1:0]  RST_B_PERIOD  = 16'd5;

  typedef enum logic [2:0] {
    ST_ACCEPT,
    ST_DECIDE,
    ST_DIV_INIT,
    ST_DIV,
    ST_EMIT,
    ST_CLEAR
  } abar_state_e;

  typedef struct packed {
    logic accept;      // add the incoming sample
    logic decide;      // update block counters, latch report flags
    logic div_start;   // load divider operand with current slot's sum
    logic div_step;    // reciprocal multiply, write the held reading
    logic out_load;    // load output register with current slot
    logic clear_sums;  // clear the block sums
    logic slot;        // slot being worked on
  } abar_cmd_t;

  typedef struct packed {
    logic block_end;   // next sample closes the block
    logic upd;         // current slot takes a new average
    logic rep;         // current slot reports
    logic out_free;    // output register can take an item
  } abar_status_t;

endpackage

`default_nettype wire

// ===== hdl/abar_ctrl.sv =====
// controller state machine of the adc block average reporter
`timescale 1ns / 1ps
`default_nettype none

module abar_ctrl #(
  parameter int unsigned SENSOR_SLOTS = 2
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  abar_pkg::abar_status_t status_i,
  output abar_pkg::abar_cmd_t    cmd_o
);
  import abar_pkg::*;

  abar_state_e state_q, state_d;
  logic        slot_q, slot_d;
  logic        last_slot;

  assign last_slot = (slot_q == 1'(SENSOR_SLOTS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCEPT;
      slot_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    slot_d     = slot_q;
    cmd_o      = '0;
    cmd_o.slot = slot_q;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_ACCEPT: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.block_end) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        slot_d       = 1'b0;
        state_d      = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        if (status_i.upd) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status_i.rep || status_i.out_free) begin
          cmd_o.out_load = status_i.rep;
          if (last_slot) begin
            state_d = ST_CLEAR;
          end else begin
            slot_d  = ~slot_q;
            state_d = ST_DIV_INIT;
          end
        end
      end
      ST_CLEAR: begin
        cmd_o.clear_sums = 1'b1;
        state_d          = ST_ACCEPT;
      end
      default: begin
        state_d = ST_ACCEPT;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/abar_datapath.sv =====
// datapath of the adc block average reporter: sums, divider, slots, output register
`timescale 1ns / 1ps
`default_nettype none

module abar_datapath #(
  parameter int unsigned ADC_CHANNELS    = 2,
  parameter int unsigned BLOCK_ROUNDS    = 16,
  parameter int unsigned SENSOR_CHANNELS = 2,
  parameter int unsigned SENSOR_SLOTS    = 2
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  abar_pkg::abar_cmd_t                   cmd_i,
  output abar_pkg::abar_status_t                status_o,
  input  wire [abar_pkg::SAMPLE_W-1:0]          sample_i,
  input  wire                                   cfg_we_i,
  input  wire [abar_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire [abar_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic [abar_pkg::CHAN_ID_W-1:0]        sensor_id_o,
  output logic [abar_pkg::READING_W-1:0]        reading_o,
  output logic [abar_pkg::TYPE_W-1:0]           sensor_type_o,
  output logic                                  last_report_o
);
  import abar_pkg::*;

  localparam int unsigned CW = (ADC_CHANNELS > 1) ? $clog2(ADC_CHANNELS) : 1;
  localparam int unsigned RW = (BLOCK_ROUNDS > 1) ? $clog2(BLOCK_ROUNDS) : 1;
  localparam int unsigned SW = SAMPLE_W + $clog2(BLOCK_ROUNDS + 1);
  localparam logic [CW-1:0] CHAN_LAST  = CW'(ADC_CHANNELS - 1);
  localparam logic [RW-1:0] ROUND_LAST = RW'(BLOCK_ROUNDS - 1);

  // division by the block length as a multiply by the rounded-up reciprocal,
  // exact for every sum that fits SW bits
  localparam int unsigned LW     = $clog2(BLOCK_ROUNDS);
  localparam int unsigned QSHIFT = SW + LW;
  localparam int unsigned MW     = SW + 1;
  localparam int unsigned PW     = SW + MW;
  localparam longint unsigned RECIP_L =
    ((64'd1 << QSHIFT) + 64'(BLOCK_ROUNDS) - 64'd1) / 64'(BLOCK_ROUNDS);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

  logic [CW-1:0]        chan_q;
  logic [RW-1:0]        round_q;
  logic [SW-1:0]        sum_q [ADC_CHANNELS];

  logic [CHAN_ID_W-1:0] channel_q [NUM_SLOTS];
  logic [TYPE_W-1:0]    type_q    [NUM_SLOTS];
  logic [PERIOD_W-1:0]  period_q  [NUM_SLOTS];
  logic [PERIOD_W-1:0]  cnt_q     [NUM_SLOTS];
  logic [READING_W-1:0] held_q    [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] rep_q, upd_q;

  logic [PERIOD_W-1:0]  cnt_d     [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] rep_d, upd_d;

  logic [SW-1:0]        op_q;
  logic [PW-1:0]        prod;
  logic [READING_W-1:0] quot;
  logic [SW-1:0]        sel_sum;

  logic                 out_valid_q;
  logic                 out_free;

  // block position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q  <= '0;
      round_q <= '0;
    end else if (cmd_i.accept) begin
      if (chan_q == CHAN_LAST) begin
        chan_q  <= '0;
        round_q <= (round_q == ROUND_LAST) ? '0 : round_q + RW'(1);
      end else begin
        chan_q <= chan_q + CW'(1);
      end
    end
  end

  // one accumulator lane per adc channel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < ADC_CHANNELS; c++) sum_q[c] <= '0;
    end else begin
      for (int c = 0; c < ADC_CHANNELS; c++) begin
        if (cmd_i.clear_sums) begin
          sum_q[c] <= '0;
        end else if (cmd_i.accept && chan_q == CW'(c)) begin
          sum_q[c] <= sum_q[c] + SW'(sample_i);
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_q[0] <= RST_A_CHANNEL;
      type_q[0]    <= RST_A_TYPE;
      period_q[0]  <= RST_A_PERIOD;
      channel_q[1] <= RST_B_CHANNEL;
      type_q[1]    <= RST_B_TYPE;
      period_q[1]  <= RST_B_PERIOD;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_A_CHANNEL: channel_q[0] <= cfg_data_i[CHAN_ID_W-1:0];
        REG_A_TYPE:    type_q[0]    <= cfg_data_i[TYPE_W-1:0];
        REG_A_PERIOD:  period_q[0]  <= cfg_data_i[PERIOD_W-1:0];
        REG_B_CHANNEL: channel_q[1] <= cfg_data_i[CHAN_ID_W-1:0];
        REG_B_TYPE:    type_q[1]    <= cfg_data_i[TYPE_W-1:0];
        REG_B_PERIOD:  period_q[1]  <= cfg_data_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // per slot block counting and report decision
  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      logic [PERIOD_W-1:0] inc;
      logic                in_range;
      inc      = cnt_q[s] + PERIOD_W'(1);
      in_range = (channel_q[s] != '0) &&
                 (channel_q[s] <= CHAN_ID_W'(SENSOR_CHANNELS)) &&
                 (channel_q[s] <= CHAN_ID_W'(ADC_CHANNELS));
      cnt_d[s] = cnt_q[s];
      rep_d[s] = 1'b0;
      if (s < SENSOR_SLOTS && period_q[s] != '0) begin
        if (inc >= period_q[s]) begin
          cnt_d[s] = '0;
          rep_d[s] = 1'b1;
        end else begin
          cnt_d[s] = inc;
        end
      end
      upd_d[s] = (s < SENSOR_SLOTS) && in_range && (period_q[s] == '0 || rep_d[s]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SLOTS; s++) cnt_q[s] <= '0;
      rep_q <= '0;
      upd_q <= '0;
    end else if (cmd_i.decide) begin
      for (int s = 0; s < NUM_SLOTS; s++) cnt_q[s] <= cnt_d[s];
      rep_q <= rep_d;
      upd_q <= upd_d;
    end
  end

  // sum of the current slot's channel
  always_comb begin
    sel_sum = '0;
    for (int c = 0; c < ADC_CHANNELS; c++) begin
      if (channel_q[cmd_i.slot] == CHAN_ID_W'(c + 1)) sel_sum = sum_q[c];
    end
  end

  // operand register, then a combinational multiply
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      op_q <= sel_sum;
    end
  end

  assign prod = PW'(op_q) * PW'(RECIP);
  assign quot = prod[QSHIFT +: READING_W];

  // held readings, written on the multiply cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SLOTS; s++) held_q[s] <= '0;
    end else if (cmd_i.div_step) begin
      held_q[cmd_i.slot] <= quot;
    end
  end

  // output register
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      sensor_id_o   <= channel_q[cmd_i.slot];
      reading_o     <= held_q[cmd_i.slot];
      sensor_type_o <= type_q[cmd_i.slot];
      last_report_o <= cmd_i.slot || (SENSOR_SLOTS < 2) || !rep_q[1];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.block_end = (chan_q == CHAN_LAST) && (round_q == ROUND_LAST);
  assign status_o.upd       = upd_q[cmd_i.slot];
  assign status_o.rep       = rep_q[cmd_i.slot];
  assign status_o.out_free  = out_free;

  // an item is never loaded over one still waiting
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("output loaded while occupied");

  // no sample enters while the divider works
  a_no_accept_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_step || cmd_i.div_start) |-> !cmd_i.accept)
    else $error("sample accepted during division");

  // position stays inside the block
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chan_q <= CHAN_LAST) && (round_q <= ROUND_LAST))
    else $error("block position out of range");

  // sums restart at the beginning of the block after the clear
  a_clear_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_sums |-> (chan_q == '0) && (round_q == '0))
    else $error("sums cleared mid block");

endmodule

`default_nettype wire

// ===== hdl/adc_block_average_reporter_unit.sv =====
// top level of the adc block average reporter
`timescale 1ns / 1ps
`default_nettype none

// adc block average reporter: takes adc samples interleaved channel by channel
// (channel 1 first) in blocks of BLOCK_ROUNDS rounds and keeps one running sum
// per channel. within a block one sample item is taken every clock cycle in
// which in_valid_i is high. the last sample of a block starts a report phase
// during which in_stall_o is high: the slot block counters are updated, then
// for each sensor slot a setup state, a pass through the shared reciprocal
// multiplier when the slot takes a new average (sum divided by BLOCK_ROUNDS,
// truncated) and a state that hands its report, if due, to the output
// register, then the sums are cleared. the phase grows with each slot that
// updates and while the output register waits on out_stall_i; the slot by
// slot sequencing sets its length. a slot with a nonzero period reports its
// held reading every period blocks; period zero only refreshes the held
// reading. a channel number of zero or beyond the channel count keeps the old
// reading, but the slot still reports when due. the last report of a block
// carries last_report_o high. configuration registers (index: a channel, a
// type, a period, b channel, b type, b period) are written with cfg_we_i;
// other indexes are ignored. write them only while the block is idle.

module adc_block_average_reporter_unit #(
  parameter int unsigned ADC_CHANNELS    = 2,
  parameter int unsigned BLOCK_ROUNDS    = 16,
  parameter int unsigned SENSOR_CHANNELS = 2,
  parameter int unsigned SENSOR_SLOTS    = 2
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // sample items
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire [abar_pkg::SAMPLE_W-1:0]     sample_i,
  // report items
  output logic                             out_valid_o,
  input  wire                              out_stall_i,
  output logic [abar_pkg::CHAN_ID_W-1:0]   sensor_id_o,
  output logic [abar_pkg::READING_W-1:0]   reading_o,
  output logic [abar_pkg::TYPE_W-1:0]      sensor_type_o,
  output logic                             last_report_o,
  // configuration writes
  input  wire                              cfg_we_i,
  input  wire [abar_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire [abar_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import abar_pkg::*;

  abar_cmd_t    cmd;
  abar_status_t status;

  // sequencing of the accept and report phases
  abar_ctrl #(
    .SENSOR_SLOTS (SENSOR_SLOTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // accumulators, divider, slot state and output register
  abar_datapath #(
    .ADC_CHANNELS    (ADC_CHANNELS),
    .BLOCK_ROUNDS    (BLOCK_ROUNDS),
    .SENSOR_CHANNELS (SENSOR_CHANNELS),
    .SENSOR_SLOTS    (SENSOR_SLOTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .sample_i      (sample_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sensor_id_o   (sensor_id_o),
    .reading_o     (reading_o),
    .sensor_type_o (sensor_type_o),
    .last_report_o (last_report_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench for the adc block average reporter: directed blocks, then random phases
`timescale 1ns / 1ps

module tb;
  import abar_pkg::*;

  // block geometry, kept equal to the parameters handed to the dut
  localparam int unsigned ADC_CH        = 2;
  localparam int unsigned ROUNDS        = 16;
  localparam int unsigned SENS_CH       = 2;
  localparam int unsigned BLOCK_SAMPLES = ADC_CH * ROUNDS;

  localparam int SLOT_A = 0;
  localparam int SLOT_B = 1;

  // indexes past the register list, the block must ignore writes there
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int DRAIN_CYCLES = 64;    // long enough for the report phase plus any output wait
  localparam int RESULT_WAIT  = 4000;  // cycles allowed for outstanding reports to show up
  localparam int RANDOM_ITEMS = 760;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [CHAN_ID_W-1:0] sensor_id;
    logic [READING_W-1:0] reading;
    logic [TYPE_W-1:0]    sensor_type;
    logic                 last_report;
  } report_t;

  // one directed block: optional register setup, then a block whose channels
  // each carry a constant level, so the average is that level
  typedef struct packed {
    logic                 reconfig;
    logic [CHAN_ID_W-1:0] chan_a;
    logic [TYPE_W-1:0]    type_a;
    logic [PERIOD_W-1:0]  per_a;
    logic [CHAN_ID_W-1:0] chan_b;
    logic [TYPE_W-1:0]    type_b;
    logic [PERIOD_W-1:0]  per_b;
    logic [SAMPLE_W-1:0]  level0;
    logic [SAMPLE_W-1:0]  level1;
    logic                 typed;   // expected reports typed in below
    logic [1:0]           n_rep;
    report_t              rep0;
    report_t              rep1;
  } block_row_t;

  localparam report_t NO_REP = '0;
  localparam int      ROWS   = 9;

  localparam block_row_t DIRECTED [ROWS] = '{
    // after reset: both slots count to 1 of 5, nothing due
    '{1'b0, 4'd1, 2'd0, 16'd5, 4'd2, 2'd1, 16'd5, 12'd4095, 12'd0,
      1'b1, 2'd0, NO_REP, NO_REP},
    // period 1 on both slots, full scale on channel 1, zero on channel 2
    '{1'b1, 4'd1, 2'd3, 16'd1, 4'd2, 2'd2, 16'd1, 12'd4095, 12'd0,
      1'b1, 2'd2, '{4'd1, 12'd4095, 2'd3, 1'b0}, '{4'd2, 12'd0, 2'd2, 1'b1}},
    '{1'b0, 4'd1, 2'd3, 16'd1, 4'd2, 2'd2, 16'd1, 12'd0, 12'd4095,
      1'b1, 2'd2, '{4'd1, 12'd0, 2'd3, 1'b0}, '{4'd2, 12'd4095, 2'd2, 1'b1}},
    // channel zero and channel 15: old readings kept, still reported
    '{1'b1, 4'd0, 2'd1, 16'd1, 4'd15, 2'd0, 16'd1, 12'h555, 12'hAAA,
      1'b1, 2'd2, '{4'd0, 12'd0, 2'd1, 1'b0}, '{4'd15, 12'd4095, 2'd0, 1'b1}},
    // period zero: readings refresh silently, counters untouched
    '{1'b1, 4'd2, 2'd2, 16'd0, 4'd1, 2'd3, 16'd0, 12'h123, 12'h456,
      1'b1, 2'd0, NO_REP, NO_REP},
    // only slot a due, so its report closes the run
    '{1'b1, 4'd0, 2'd0, 16'd1, 4'd1, 2'd1, 16'd65535, 12'h800, 12'h7FF,
      1'b1, 2'd1, '{4'd0, 12'h456, 2'd0, 1'b1}, NO_REP},
    '{1'b0, 4'd0, 2'd0, 16'd1, 4'd1, 2'd1, 16'd65535, 12'h0F0, 12'h00F,
      1'b0, 2'd0, NO_REP, NO_REP},
    // slot b period lowered below its count: reports on the next block
    '{1'b1, 4'd2, 2'd3, 16'd65535, 4'd1, 2'd2, 16'd1, 12'hFFF, 12'h001,
      1'b0, 2'd0, NO_REP, NO_REP},
    '{1'b1, 4'd3, 2'd0, 16'd2, 4'd2, 2'd1, 16'd3, 12'h3C3, 12'hC3C,
      1'b0, 2'd0, NO_REP, NO_REP}
  };

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic [SAMPLE_W-1:0]  sample_i      = '0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic [CHAN_ID_W-1:0] sensor_id_o;
  logic [READING_W-1:0] reading_o;
  logic [TYPE_W-1:0]    sensor_type_o;
  logic                 last_report_o;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;

  adc_block_average_reporter_unit #(
    .ADC_CHANNELS   (ADC_CH),
    .BLOCK_ROUNDS   (ROUNDS),
    .SENSOR_CHANNELS(SENS_CH),
    .SENSOR_SLOTS   (NUM_SLOTS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sensor_id_o  (sensor_id_o),
    .reading_o    (reading_o),
    .sensor_type_o(sensor_type_o),
    .last_report_o(last_report_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // mirror of the block: registers, block position, sums, counters, readings
  logic [CHAN_ID_W-1:0] slot_chan   [NUM_SLOTS];
  logic [TYPE_W-1:0]    slot_type   [NUM_SLOTS];
  logic [PERIOD_W-1:0]  slot_period [NUM_SLOTS];
  logic [15:0]          slot_count  [NUM_SLOTS];
  logic [READING_W-1:0] slot_held   [NUM_SLOTS];
  logic [15:0]          chan_sum    [ADC_CH];
  int unsigned          blk_pos;

  report_t expected_reports [$];
  int      mismatches    = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the handshakes hang
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // one sample into the mirror; returns the reports that the sample closes
  function automatic int accumulate_sample(input logic [SAMPLE_W-1:0] v,
                                           output report_t [1:0] reps);
    logic [READING_W-1:0] avg [ADC_CH];
    logic [CHAN_ID_W-1:0] id;
    bit                   in_range;
    bit                   due;
    int                   n;
    int                   ch;
    int                   s;
    n    = 0;
    reps = '0;
    if (blk_pos >= BLOCK_SAMPLES) blk_pos = 0;
    ch = blk_pos % ADC_CH;
    chan_sum[ch] += 16'(v);
    blk_pos++;
    if (blk_pos < BLOCK_SAMPLES) return 0;
    blk_pos = 0;
    for (ch = 0; ch < ADC_CH; ch++) begin
      avg[ch]      = READING_W'(chan_sum[ch] / ROUNDS);
      chan_sum[ch] = '0;
    end
    for (s = 0; s < NUM_SLOTS; s++) begin
      id       = slot_chan[s];
      in_range = id >= 1 && id <= SENS_CH && id <= ADC_CH;
      due      = 1'b0;
      // period zero freezes the counter and never reports
      if (slot_period[s] != '0) begin
        slot_count[s] = slot_count[s] + 16'd1;
        if (slot_count[s] >= slot_period[s]) begin
          slot_count[s] = '0;
          due           = 1'b1;
        end
      end
      if (in_range && (slot_period[s] == '0 || due)) slot_held[s] = avg[id - 1];
      if (due) begin
        reps[n] = '{id, slot_held[s], slot_type[s], 1'b0};
        n++;
      end
    end
    if (n > 0) reps[n - 1].last_report = 1'b1;
    return n;
  endfunction

  task automatic mirror_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_A_CHANNEL: slot_chan[SLOT_A]   = data[CHAN_ID_W-1:0];
      REG_A_TYPE:    slot_type[SLOT_A]   = data[TYPE_W-1:0];
      REG_A_PERIOD:  slot_period[SLOT_A] = data[PERIOD_W-1:0];
      REG_B_CHANNEL: slot_chan[SLOT_B]   = data[CHAN_ID_W-1:0];
      REG_B_TYPE:    slot_type[SLOT_B]   = data[TYPE_W-1:0];
      REG_B_PERIOD:  slot_period[SLOT_B] = data[PERIOD_W-1:0];
      default: ;
    endcase
  endtask

  // called at a rising edge; leaves the write enable high for the caller
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    mirror_reg(idx, data);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] chan_a, type_a, per_a,
                                input logic [CFG_DATA_W-1:0] chan_b, type_b, per_b,
                                input bit add_spare);
    write_reg(REG_A_CHANNEL, chan_a);
    write_reg(REG_A_TYPE, type_a);
    write_reg(REG_A_PERIOD, per_a);
    if (add_spare) write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
                             CFG_DATA_W'($urandom));
    write_reg(REG_B_CHANNEL, chan_b);
    write_reg(REG_B_TYPE, type_b);
    write_reg(REG_B_PERIOD, per_b);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idle_mode(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 45; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 45; end
      default:       begin send_idle_pct = 13; recv_stall_pct = 13; end
    endcase
  endtask

  // called at a rising edge, returns at the edge that takes the item
  task automatic push_sample(input logic [SAMPLE_W-1:0] v, input bit typed);
    report_t [1:0] reps;
    int            n;
    int            i;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n = accumulate_sample(v, reps);
    // typed rows bring their own expectations
    if (!typed)
      for (i = 0; i < n; i++) expected_reports.push_back(reps[i]);
  endtask

  // sender holds off until every report is in, then lets the report phase finish
  task automatic wait_idle();
    int guard;
    in_valid_i <= 1'b0;
    guard = 0;
    while (expected_reports.size() != 0 && guard < RESULT_WAIT) begin
      @(posedge clk_i);
      guard++;
    end
    if (expected_reports.size() != 0) begin
      flag_mismatch($sformatf("%0d reports never arrived", expected_reports.size()));
      expected_reports.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [CHAN_ID_W-1:0] pick_channel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return CHAN_ID_W'($urandom_range(15, 3));
      default: return CHAN_ID_W'($urandom_range(2, 1));
    endcase
  endfunction

  function automatic logic [PERIOD_W-1:0] pick_period();
    case ($urandom_range(19))
      0, 1:    return '0;
      2:       return '1;
      3:       return PERIOD_W'($urandom);
      4, 5, 6: return PERIOD_W'($urandom_range(8, 4));
      default: return PERIOD_W'($urandom_range(3, 1));
    endcase
  endfunction

  task automatic check_report(input report_t got);
    report_t want;
    if (expected_reports.size() == 0) begin
      flag_mismatch($sformatf("unexpected report id %0d reading %0d",
                              got.sensor_id, got.reading));
    end else begin
      want = expected_reports.pop_front();
      if (got.sensor_id != want.sensor_id)
        flag_mismatch($sformatf("sensor_id %0d, want %0d", got.sensor_id, want.sensor_id));
      if (got.reading != want.reading)
        flag_mismatch($sformatf("reading %0d, want %0d", got.reading, want.reading));
      if (got.sensor_type != want.sensor_type)
        flag_mismatch($sformatf("sensor_type %0d, want %0d",
                                got.sensor_type, want.sensor_type));
      if (got.last_report != want.last_report)
        flag_mismatch($sformatf("last_report %0b, want %0b",
                                got.last_report, want.last_report));
    end
  endtask

  // report side: take items, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        check_report('{sensor_id_o, reading_o, sensor_type_o, last_report_o});
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    block_row_t          row;
    logic [SAMPLE_W-1:0] v;
    int                  r;
    int                  k;
    int                  len;
    int                  phase;
    int                  sent_random;

    // mirror starts from the reset state
    slot_chan[SLOT_A]   = RST_A_CHANNEL;
    slot_type[SLOT_A]   = RST_A_TYPE;
    slot_period[SLOT_A] = RST_A_PERIOD;
    slot_chan[SLOT_B]   = RST_B_CHANNEL;
    slot_type[SLOT_B]   = RST_B_TYPE;
    slot_period[SLOT_B] = RST_B_PERIOD;
    for (k = 0; k < NUM_SLOTS; k++) begin
      slot_count[k] = '0;
      slot_held[k]  = '0;
    end
    for (k = 0; k < ADC_CH; k++) chan_sum[k] = '0;
    blk_pos = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed blocks, each one whole block of constant channel levels
    for (r = 0; r < ROWS; r++) begin
      row = DIRECTED[r];
      set_idle_mode(idle_mode_e'(r % 4));
      if (row.reconfig) begin
        wait_idle();
        apply_settings(CFG_DATA_W'(row.chan_a), CFG_DATA_W'(row.type_a), row.per_a,
                       CFG_DATA_W'(row.chan_b), CFG_DATA_W'(row.type_b), row.per_b, 1'b0);
      end
      for (k = 0; k < BLOCK_SAMPLES; k++)
        push_sample((k % ADC_CH == 0) ? row.level0 : row.level1, row.typed);
      if (row.typed) begin
        if (row.n_rep > 0) expected_reports.push_back(row.rep0);
        if (row.n_rep > 1) expected_reports.push_back(row.rep1);
      end
    end

    // random phases: new settings, mostly whole blocks, some ending mid block
    sent_random = 0;
    phase       = 0;
    while (sent_random < RANDOM_ITEMS) begin
      set_idle_mode(idle_mode_e'(phase % 4));
      wait_idle();
      // junk above the field width must be dropped by the block
      apply_settings({12'($urandom), pick_channel()}, {14'($urandom), 2'($urandom)},
                     pick_period(),
                     {12'($urandom), pick_channel()}, {14'($urandom), 2'($urandom)},
                     pick_period(), $urandom_range(2) == 0);
      if ($urandom_range(3) != 0) len = BLOCK_SAMPLES * $urandom_range(3, 1);
      else len = $urandom_range(80, 1);
      for (k = 0; k < len; k++) begin
        case ($urandom_range(9))
          0:       v = '0;
          1:       v = '1;
          default: v = SAMPLE_W'($urandom);
        endcase
        push_sample(v, 1'b0);
        sent_random++;
      end
      phase++;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
